// File: src/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the sorted array table: operation and
// status codes, fixed field widths and the command word sent to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  // Fixed widths of the request and response fields
  localparam int OP_W    = 2;
  localparam int KEY_IN_W = 32;
  localparam int POS_W   = 6;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_AT = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE     = 2'd2;
  localparam logic [OP_W-1:0] OP_SEARCH    = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Search miss, also reported for every op that is not a search
  localparam logic [IDX_W-1:0] FOUND_NONE = 7'h7F;

  // Shift command broadcast along the row of cells
  typedef struct packed {
    logic ins;     // open a slot before the first entry >= key
    logic del_at;  // close the gap at the given position
    logic purge;   // drop the first entry equal to key
  } sat_cmd_t;

endpackage

`default_nettype wire

// File: src/sat_req_if.sv
// ----------------------------------------------------------------------------
// sat_req_if
// Request channel: valid/ready handshake carrying op, key and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface sat_req_if;
  logic                          valid;
  logic                          ready;
  logic [sat_pkg::OP_W-1:0]      op;
  logic [sat_pkg::KEY_IN_W-1:0]  key;
  logic [sat_pkg::POS_W-1:0]     position;

  modport source (output valid, output op, output key, output position, input ready);
  modport sink   (input valid, input op, input key, input position, output ready);
endinterface

`default_nettype wire

// File: src/sat_rsp_if.sv
// ----------------------------------------------------------------------------
// sat_rsp_if
// Response channel: valid/ready handshake carrying the search index, the
// entry count and the status of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sat_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sat_pkg::IDX_W-1:0]   found_index;
  logic [sat_pkg::CNT_W-1:0]   entry_count;
  logic [sat_pkg::STAT_W-1:0]  status;

  modport source (output valid, output found_index, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input found_index, input entry_count, input status,
                  output ready);
endinterface

`default_nettype wire

// File: src/sat_cell.sv
// ----------------------------------------------------------------------------
// sat_cell
// One slot of the sorted row. Holds a key, compares it with the current
// request key and takes its left or right neighbour's key, or the request key, on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_cell #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  parameter int INDEX     = 0
) (
  input  wire logic                             clk,
  input  wire sat_pkg::sat_cmd_t                cmd,
  input  wire logic [$clog2(DEPTH+1)-1:0]       count,
  input  wire logic [sat_pkg::POS_W-1:0]        pos,
  input  wire logic [KEY_WIDTH-1:0]             new_key,
  input  wire logic [KEY_WIDTH-1:0]             left_key,
  input  wire logic                             left_ge,
  input  wire logic [KEY_WIDTH-1:0]             right_key,
  output logic      [KEY_WIDTH-1:0]             key,
  output logic                                  ge,
  output logic                                  eq
);

  localparam int CW = $clog2(DEPTH+1);

  logic                 occupied;
  logic                 past_pos;
  logic [KEY_WIDTH-1:0] key_next;

  // Local compares against the request key
  assign occupied = (CW'(INDEX) < count);
  assign past_pos = (32'(INDEX) >= 32'(pos));
  assign ge       = occupied && (key >= new_key);
  assign eq       = occupied && (key == new_key);

  // Pick the next key from the neighbours or the request
  always_comb begin
    key_next = key;
    priority if (cmd.ins) begin
      if (left_ge) begin
        key_next = left_key;
      end else if (ge || !occupied) begin
        key_next = new_key;
      end
    end else if (cmd.del_at) begin
      if (past_pos) begin
        key_next = right_key;
      end
    end else if (cmd.purge) begin
      if (ge) begin
        key_next = right_key;
      end
    end
  end

  // Hold the key
  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

`default_nettype wire

// File: src/sorted_array_table.sv
// ----------------------------------------------------------------------------
// sorted_array_table
// Ascending sorted key table held in a row of shifting cells, with sorted
// insert, remove at position, remove of all equal keys and binary search.
// ----------------------------------------------------------------------------
// Usage: one request beat (op, key, position) on req gives exactly one
// response beat (found_index, entry_count, status) on rsp. Items are worked
// one at a time; req.ready is high only while the block is free.
// Sequence after a request is accepted: S_CMP, then
//   insert, remove at position : straight to S_POST
//   remove all equal           : S_PURGE until no equal entry is left, then S_POST
//   search                     : S_SEARCH until a hit or an empty window,
//                                one probe per step, then S_POST
// S_POST loads the response and returns to S_IDLE; a new request is taken
// the cycle after the response is loaded. The control sequencer shifts the
// whole row at once, removes one entry per cycle on a purge and makes one
// probe per cycle on a search.
// Reset empties the table (count to zero) and drops any pending response.
// If the receiver stalls, the response is held in the output register and
// the block finishes the next item only up to the point of loading it.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_table #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  sat_req_if.sink   req,
  sat_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PURGE,
    S_SEARCH,
    S_POST
  } state_t;

  state_t                         state;
  logic [sat_pkg::OP_W-1:0]       op_q;
  logic [KEY_WIDTH-1:0]           key_q;
  logic [sat_pkg::POS_W-1:0]      pos_q;
  logic [CW-1:0]                  count;
  logic signed [CW:0]             lo;
  logic signed [CW:0]             hi;
  logic [sat_pkg::IDX_W-1:0]      found_q;
  logic [sat_pkg::STAT_W-1:0]     status_q;

  sat_pkg::sat_cmd_t              cmd;
  logic [KEY_WIDTH-1:0]           keys [DEPTH];
  logic [DEPTH-1:0]               ge_vec;
  logic [DEPTH-1:0]               eq_vec;
  logic                           full;
  logic                           pos_bad;
  logic                           any_eq;
  logic [CW:0]                    mid_sum;
  logic [IW-1:0]                  mid;

  // Request compares
  assign full    = (count == CW'(DEPTH));
  assign pos_bad = (32'(pos_q) >= 32'(count));
  assign any_eq  = |eq_vec;

  // Midpoint of the search window, rounded down
  assign mid_sum = {1'b0, lo[CW-1:0]} + {1'b0, hi[CW-1:0]};
  assign mid     = mid_sum[IW:1];

  // Shift command for the row
  always_comb begin
    cmd        = '0;
    cmd.ins    = (state == S_CMP) && (op_q == sat_pkg::OP_INSERT) && !full;
    cmd.del_at = (state == S_CMP) && (op_q == sat_pkg::OP_REMOVE_AT) && !pos_bad;
    cmd.purge  = (state == S_PURGE) && any_eq;
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key;
    logic                 left_ge;
    logic [KEY_WIDTH-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_ge  = 1'b0;
    end else begin : g_inner
      assign left_key = keys[i-1];
      assign left_ge  = ge_vec[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_body
      assign right_key = keys[i+1];
    end

    sat_cell #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .pos       (pos_q),
      .new_key   (key_q),
      .left_key  (left_key),
      .left_ge   (left_ge),
      .right_key (right_key),
      .key       (keys[i]),
      .ge        (ge_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  assign req.ready = (state == S_IDLE);

  // Sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_POST) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_q     <= req.op;
            key_q    <= KEY_WIDTH'(req.key);
            pos_q    <= req.position;
            found_q  <= sat_pkg::FOUND_NONE;
            status_q <= sat_pkg::ST_DONE;
            state    <= S_CMP;
          end
        end
        S_CMP: begin
          unique case (op_q)
            sat_pkg::OP_INSERT: begin
              if (full) begin
                status_q <= sat_pkg::ST_FULL;
              end else begin
                count <= count + CW'(1);
              end
              state <= S_POST;
            end
            sat_pkg::OP_REMOVE_AT: begin
              if (pos_bad) begin
                status_q <= sat_pkg::ST_RANGE;
              end else begin
                count <= count - CW'(1);
              end
              state <= S_POST;
            end
            sat_pkg::OP_PURGE: begin
              state <= S_PURGE;
            end
            default: begin
              lo    <= '0;
              hi    <= $signed({1'b0, count}) - (CW+1)'(1);
              state <= S_SEARCH;
            end
          endcase
        end
        S_PURGE: begin
          // drop one equal entry per cycle until none is left
          if (any_eq) begin
            count <= count - CW'(1);
          end else begin
            state <= S_POST;
          end
        end
        S_SEARCH: begin
          priority if (lo > hi) begin
            state <= S_POST;
          end else if (eq_vec[mid]) begin
            found_q <= sat_pkg::IDX_W'(mid);
            state   <= S_POST;
          end else if (ge_vec[mid]) begin
            hi <= $signed({1'b0, mid_sum[CW:1]}) - (CW+1)'(1);
          end else begin
            lo <= $signed({1'b0, mid_sum[CW:1]}) + (CW+1)'(1);
          end
        end
        S_POST: begin
          // load the response once the register is free, else hold it
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.found_index <= found_q;
            rsp.entry_count <= sat_pkg::CNT_W'(count);
            rsp.status      <= status_q;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count above table size");

  // A full status is only given for a full table
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_POST && status_q == sat_pkg::ST_FULL) |-> full)
    else $error("full status with free slots");

  // Search window stays inside the valid entries
  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (hi < $signed({1'b0, count}) && lo <= $signed({1'b0, count})))
    else $error("search window outside the table");

  // Count moves only while shifting the row
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_CMP && state != S_PURGE) |=> (count == $past(count)))
    else $error("count changed outside a shift");

endmodule

`default_nettype wire
